// ----- src/adpcm_block_decoder_unit_defines.svh -----
// Assertion macros shared by the ADPCM block decoder RTL.
// Expects signals named clk and rst_n in the scope of each use.
// Define NO_ASSERTIONS to compile all checks away.
`ifndef ADPCM_BLOCK_DECODER_UNIT_DEFINES_SVH
`define ADPCM_BLOCK_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ADPCM_BD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ADPCM_BD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ADPCM_BD_ASSERT(name, prop, msg)
`define ADPCM_BD_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ----- src/adpcm_bd_pkg.sv -----
// Package for the ADPCM block decoder: constants, types and the filter table.
// Used by the channel interfaces, the sample decoder and the top level.
`default_nettype none

package adpcm_bd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FLAGS_W   = 3;

  localparam logic signed [18:0] SAMPLE_LIMIT_POS = 19'sd32767;
  localparam logic signed [18:0] SAMPLE_LIMIT_NEG = -19'sd32767;

  localparam logic [3:0] BASE_SHIFT   = 4'd12;
  localparam logic [3:0] MAX_SHIFT    = 4'd12;
  localparam logic [3:0] ALT_SHIFT    = 4'd9;
  localparam int         FRAC_BITS    = 6;
  localparam logic signed [24:0] FRAC_ROUND = 25'sd32;
  localparam logic signed [24:0] FRAC_BIAS  = 25'sd63;

  // Positions within a 16-byte block.
  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_LAST   = 4'd15;

  // Predictor filter codes.
  localparam logic [3:0] FILT_NONE = 4'd0;
  localparam logic [3:0] FILT_ONE  = 4'd1;
  localparam logic [3:0] FILT_TWO  = 4'd2;
  localparam logic [3:0] FILT_THREE = 4'd3;
  localparam logic [3:0] FILT_FOUR = 4'd4;

  typedef struct packed {
    logic [6:0] c1;
    logic [5:0] c2;
  } coef_t;

  typedef struct packed {
    logic [3:0] shift;
    logic [3:0] filter;
  } decode_ctl_t;

  // Two-tap predictor weights in 1/64 units; unused codes predict nothing.
  function automatic coef_t filter_coef(input logic [3:0] filt);
    coef_t cf;
    unique case (filt)
      FILT_ONE:   cf = '{c1: 7'd60,  c2: 6'd0};
      FILT_TWO:   cf = '{c1: 7'd115, c2: 6'd52};
      FILT_THREE: cf = '{c1: 7'd98,  c2: 6'd55};
      FILT_FOUR:  cf = '{c1: 7'd122, c2: 6'd60};
      default:    cf = '{c1: 7'd0,   c2: 6'd0};
    endcase
    return cf;
  endfunction

endpackage

`default_nettype wire

// ----- src/adpcm_bd_if.sv -----
// Valid/ready channel interfaces for the ADPCM block decoder.
// Depends on adpcm_bd_pkg for the payload widths.
`default_nettype none

interface adpcm_bd_in_if;
  import adpcm_bd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       clear_history;

  modport source (output valid, output byte_value, output clear_history, input ready);
  modport sink   (input valid, input byte_value, input clear_history, output ready);
endinterface

interface adpcm_bd_out_if;
  import adpcm_bd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pcm_sample;
  logic                       pair_last;
  logic                       block_done;
  logic [FLAGS_W-1:0]         loop_flags;

  modport source (output valid, output pcm_sample, output pair_last, output block_done,
                  output loop_flags, input ready);
  modport sink   (input valid, input pcm_sample, input pair_last, input block_done,
                  input loop_flags, output ready);
endinterface

`default_nettype wire

// ----- src/adpcm_bd_decode.sv -----
// Combinational decode of one 4-bit residue into a clamped 16-bit sample.
// Depends on adpcm_bd_pkg for the filter table and constants.
`default_nettype none

module adpcm_bd_decode
  import adpcm_bd_pkg::*;
(
  input  logic [3:0]                 nibble,
  input  decode_ctl_t                ctl,
  input  logic signed [SAMPLE_W-1:0] newer,
  input  logic signed [SAMPLE_W-1:0] older,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic [3:0]        shift_eff;
  logic [3:0]        scale_amt;
  logic signed [17:0] scaled;
  coef_t             cf;
  logic signed [24:0] c1_s;
  logic signed [24:0] c2_s;
  logic signed [24:0] newer_s;
  logic signed [24:0] older_s;
  logic signed [24:0] term;
  logic signed [24:0] biased;
  logic signed [24:0] quot;
  logic signed [18:0] sum;

  always_comb begin
    shift_eff = (ctl.shift > MAX_SHIFT) ? ALT_SHIFT : ctl.shift;
    scale_amt = BASE_SHIFT - shift_eff;
    scaled    = $signed({{14{nibble[3]}}, nibble}) <<< scale_amt;

    cf      = filter_coef(ctl.filter);
    c1_s    = $signed({18'd0, cf.c1});
    c2_s    = $signed({19'd0, cf.c2});
    newer_s = $signed({{9{newer[15]}}, newer});
    older_s = $signed({{9{older[15]}}, older});
    term    = c1_s * newer_s - c2_s * older_s + FRAC_ROUND;

    // Bias negative values so the shift truncates toward zero.
    biased = term[24] ? term + FRAC_BIAS : term;
    quot   = biased >>> FRAC_BITS;
    sum    = $signed({scaled[17], scaled}) + quot[18:0];

    if (sum > SAMPLE_LIMIT_POS) begin
      sample = SAMPLE_LIMIT_POS[15:0];
    end else if (sum < SAMPLE_LIMIT_NEG) begin
      sample = SAMPLE_LIMIT_NEG[15:0];
    end else begin
      sample = sum[15:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/adpcm_block_decoder_unit.sv -----
// ADPCM block decoder top level: byte parsing, history and the output register.
// Depends on adpcm_bd_pkg, adpcm_bd_if, adpcm_bd_decode and the defines header.
//
// Usage: raw bytes of 16-byte ADPCM blocks enter on in_ch, one per transaction.
// Byte 0 of a block sets shift and filter, byte 1 sets the loop flags, and each
// of bytes 2 to 15 produces two samples on out_ch, low nibble first. Setting
// clear_history zeroes the predictor history and treats that byte as byte 0.
// Header and flag bytes are absorbed and produce no output.
// A data byte is held in an input register; its first sample is decoded from
// it and loaded into the output register, then its second, since the second
// sample depends on the first. The single decode unit produces one sample per
// cycle while the receiver does not stall. The next byte is accepted in the
// cycle the second sample is loaded. When the receiver stalls, the output
// register holds its sample and the decoder waits, and in_ch.ready falls once
// a data byte is pending.
// Synchronous reset clears the block position, shift, filter, loop flags and
// history, and empties the input and output registers.
`default_nettype none
`include "adpcm_block_decoder_unit_defines.svh"

module adpcm_block_decoder_unit
  import adpcm_bd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  adpcm_bd_in_if.sink    in_ch,
  adpcm_bd_out_if.source out_ch
);

  // Block parsing state.
  logic [3:0]                 pos_r, pos_nxt;
  logic [3:0]                 shift_r, shift_nxt;
  logic [3:0]                 filter_r, filter_nxt;
  logic [FLAGS_W-1:0]         flags_r, flags_nxt;
  logic signed [SAMPLE_W-1:0] hist_newer_r, hist_newer_nxt;
  logic signed [SAMPLE_W-1:0] hist_older_r, hist_older_nxt;

  // Pending data byte.
  logic                       busy_r, busy_nxt;
  logic                       phase_r, phase_nxt;
  logic [7:0]                 data_r, data_nxt;
  logic                       done_r, done_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_pair_last_r, out_pair_last_nxt;
  logic                       out_block_done_r, out_block_done_nxt;
  logic [FLAGS_W-1:0]         out_flags_r, out_flags_nxt;

  logic                       advance;
  logic                       in_ready;
  logic                       accept;
  logic [3:0]                 pos_eff;
  logic [3:0]                 nibble;
  decode_ctl_t                dec_ctl;
  logic signed [SAMPLE_W-1:0] dec_sample;

  assign advance  = busy_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !busy_r || (phase_r && advance);
  assign accept   = in_ch.valid && in_ready;
  assign nibble   = phase_r ? data_r[7:4] : data_r[3:0];
  assign dec_ctl  = '{shift: shift_r, filter: filter_r};

  adpcm_bd_decode u_decode (
    .nibble (nibble),
    .ctl    (dec_ctl),
    .newer  (hist_newer_r),
    .older  (hist_older_r),
    .sample (dec_sample)
  );

  always_comb begin
    pos_nxt            = pos_r;
    shift_nxt          = shift_r;
    filter_nxt         = filter_r;
    flags_nxt          = flags_r;
    hist_newer_nxt     = hist_newer_r;
    hist_older_nxt     = hist_older_r;
    busy_nxt           = busy_r;
    phase_nxt          = phase_r;
    data_nxt           = data_r;
    done_nxt           = done_r;
    out_valid_nxt      = out_valid_r;
    out_sample_nxt     = out_sample_r;
    out_pair_last_nxt  = out_pair_last_r;
    out_block_done_nxt = out_block_done_r;
    out_flags_nxt      = out_flags_r;
    pos_eff            = in_ch.clear_history ? POS_HEADER : pos_r;

    if (advance) begin
      out_valid_nxt      = 1'b1;
      out_sample_nxt     = dec_sample;
      out_pair_last_nxt  = phase_r;
      out_block_done_nxt = phase_r && done_r;
      out_flags_nxt      = flags_r;
      hist_older_nxt     = hist_newer_r;
      hist_newer_nxt     = dec_sample;
      if (phase_r) begin
        busy_nxt  = 1'b0;
        phase_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // A new byte takes effect after the pending sample, so a clear wins here.
    if (accept) begin
      if (in_ch.clear_history) begin
        hist_newer_nxt = '0;
        hist_older_nxt = '0;
      end
      unique case (pos_eff)
        POS_HEADER: begin
          shift_nxt  = in_ch.byte_value[3:0];
          filter_nxt = in_ch.byte_value[7:4];
          pos_nxt    = POS_FLAGS;
        end
        POS_FLAGS: begin
          flags_nxt = in_ch.byte_value[FLAGS_W-1:0];
          pos_nxt   = POS_FLAGS + 4'd1;
        end
        default: begin
          data_nxt  = in_ch.byte_value;
          done_nxt  = (pos_eff == POS_LAST);
          busy_nxt  = 1'b1;
          phase_nxt = 1'b0;
          pos_nxt   = pos_eff + 4'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_HEADER;
      shift_r      <= '0;
      filter_r     <= FILT_NONE;
      flags_r      <= '0;
      hist_newer_r <= '0;
      hist_older_r <= '0;
      busy_r       <= 1'b0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      shift_r      <= shift_nxt;
      filter_r     <= filter_nxt;
      flags_r      <= flags_nxt;
      hist_newer_r <= hist_newer_nxt;
      hist_older_r <= hist_older_nxt;
      busy_r       <= busy_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r           <= data_nxt;
    done_r           <= done_nxt;
    out_sample_r     <= out_sample_nxt;
    out_pair_last_r  <= out_pair_last_nxt;
    out_block_done_r <= out_block_done_nxt;
    out_flags_r      <= out_flags_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pcm_sample = out_sample_r;
  assign out_ch.pair_last  = out_pair_last_r;
  assign out_ch.block_done = out_block_done_r;
  assign out_ch.loop_flags = out_flags_r;

  `ADPCM_BD_ASSERT_NEVER(a_no_accept_mid_pair, busy_r && !phase_r && in_ready, "byte accepted before first sample of pair")
  `ADPCM_BD_ASSERT(a_first_then_second, (busy_r && !phase_r && advance) |=> (busy_r && phase_r), "second sample of pair lost")
  `ADPCM_BD_ASSERT(a_done_on_second, (out_valid_r && out_block_done_r) |-> out_pair_last_r, "block end flagged on first sample of pair")
  `ADPCM_BD_ASSERT_NEVER(a_sample_range, out_valid_r && (out_sample_r == -16'sd32768), "sample outside clamp range")

endmodule

`default_nettype wire
